// ===== rtl/cpcf_pkg.sv =====
// Shared package of the closed-path camera follower: word types, kinds, widths,
// CORDIC angle table. No dependencies.
`default_nettype none
package cpcf_pkg;

	localparam int NUM_PATHS_DEF       = 8;
	localparam int POINTS_PER_PATH_DEF = 1024;
	localparam int CORDIC_STEPS        = 21;

	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_QUERY  = 2'd3;

	localparam logic signed [47:0] DEG90  = 48'sd5898240;
	localparam logic signed [47:0] DEG180 = 48'sd11796480;
	localparam logic signed [47:0] DEG360 = 48'sd23592960;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         path_id;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               direction;
		logic signed [31:0] position;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic [25:0]        yaw;
		logic signed [23:0] pitch;
		logic               roll;
	} out_word_t;

	function automatic logic [21:0] atan_tab(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cpcf_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module cpcf_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/closed_path_camera_follower_unit.sv =====
// Closed-path camera follower, top level.
// Depends on cpcf_pkg and cpcf_ram.
//
// Usage:
//   in_valid/in_ready carry one in_word_t word. Kinds start, append and clear
//   update the point store or the per-path counts and give no result; a
//   query gives exactly one out_word_t word on out_valid/out_ready.
//   Points of all paths live in one RAM (x,y,z side by side, one entry per
//   point, registered read). A single sequencer works through one word at a
//   time: start and append words pass through a load state, clear words are
//   done when taken. A query walks the segments of the path twice (all of
//   them to sum the loop length, then up to the one holding the position),
//   each segment costing two RAM reads, three 33x33 squarings and a 35-step
//   bit-serial root, with a restoring modulo of the position between the two
//   passes. Then a restoring division for t, reads of the segment ends and
//   the target point, three multiplications, a root for the horizontal
//   distance and two 21-step CORDIC runs with up to 40 normalising doublings
//   each follow; the root unit dominates the query time.
//   Reset clears the counts at once; no clearing pass is needed since only
//   written entries are read. A stalled receiver holds the result in the
//   output register and the block takes no new word until it is taken.
`default_nettype none
module closed_path_camera_follower_unit #(
	parameter int NUM_PATHS       = cpcf_pkg::NUM_PATHS_DEF,
	parameter int POINTS_PER_PATH = cpcf_pkg::POINTS_PER_PATH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cpcf_pkg::in_word_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cpcf_pkg::out_word_t     out_data
);
	localparam int PW    = $clog2(POINTS_PER_PATH);
	localparam int CW    = $clog2(POINTS_PER_PATH + 1);
	localparam int PIDW  = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
	localparam int DEPTH = NUM_PATHS * POINTS_PER_PATH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [24:0] {
		S_IDLE   = 25'h0000001,
		S_LOAD   = 25'h0000002,
		S_QSTART = 25'h0000004,
		S_RD0    = 25'h0000008,
		S_RD1    = 25'h0000010,
		S_RDW    = 25'h0000020,
		S_SQ     = 25'h0000040,
		S_ROOT   = 25'h0000080,
		S_SEGDN  = 25'h0000100,
		S_MOD    = 25'h0000200,
		S_DIV    = 25'h0000400,
		S_TRD0   = 25'h0000800,
		S_TRD1   = 25'h0001000,
		S_TRD2   = 25'h0002000,
		S_TRDW   = 25'h0004000,
		S_LERP   = 25'h0008000,
		S_LERP2  = 25'h0010000,
		S_HSQ    = 25'h0020000,
		S_HROOT  = 25'h0040000,
		S_ATINIT = 25'h0080000,
		S_ATNORM = 25'h0100000,
		S_ATRUN  = 25'h0200000,
		S_ATDONE = 25'h0400000,
		S_OUT    = 25'h0800000,
		S_ONEPT  = 25'h1000000
	} state_t;

	state_t state_q;

	// control and query registers
	cpcf_pkg::in_word_t cmd_q;
	logic [CW-1:0]  cnt_q [NUM_PATHS];
	logic [CW-1:0]  len_q;
	logic [PIDW-1:0] pid_q;
	logic           pass_q;      // 0 summing lengths, 1 searching
	logic [PW-1:0]  idx_q;
	logic [PW-1:0]  nxt_q;
	logic [95:0]    pa_q;        // point i
	logic [95:0]    pb_q;        // point i+1
	logic [95:0]    pt_q;        // target point
	logic [1:0]     sqi_q;
	logic [67:0]    sum_q;
	logic [34:0]    root_q;
	logic [5:0]     bit_q;
	logic [44:0]    total_q;
	logic [44:0]    cur_q;
	logic [44:0]    pos_q;
	logic [44:0]    seg_q;
	logic [44:0]    rem_q;
	logic [63:0]    quo_q;
	logic [6:0]     step_q;
	logic [30:0]    t_q;
	logic [1:0]     ax_q;
	logic signed [33:0] cam_q [3];
	logic signed [33:0] dd_q [3];
	logic           at_sel_q;    // 0 yaw, 1 pitch
	logic signed [47:0] ax_x_q, ax_y_q, ang_q;
	logic [4:0]     ci_q;
	logic signed [47:0] yaw_q;
	cpcf_pkg::out_word_t out_q;
	logic           out_v_q;

	// point RAM
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [95:0]   ram_wdata, ram_rdata;

	cpcf_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	function automatic logic [AW-1:0] pt_addr(input logic [PIDW-1:0] p, input logic [PW-1:0] i);
		logic [AW-1:0] a;
		a = AW'(p) * AW'(POINTS_PER_PATH) + AW'(i);
		return a;
	endfunction

	function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] i, input logic [CW-1:0] n);
		logic [CW:0] j;
		j = {1'b0, CW'(i)} + 1'b1;
		return (j >= {1'b0, n}) ? '0 : j[PW-1:0];
	endfunction

	// squaring operand chosen per axis
	logic signed [32:0] sq_d;
	logic [32:0]        sq_m;
	logic [65:0]        sq_p;
	always_comb begin
		case (sqi_q)
			2'd0:    sq_d = 33'(signed'(pb_q[95:64])) - 33'(signed'(pa_q[95:64]));
			2'd1:    sq_d = 33'(signed'(pb_q[63:32])) - 33'(signed'(pa_q[63:32]));
			default: sq_d = 33'(signed'(pb_q[31:0]))  - 33'(signed'(pa_q[31:0]));
		endcase
		sq_m = sq_d[32] ? 33'(-sq_d) : 33'(sq_d);
		sq_p = sq_m * sq_m;
	end

	// horizontal squaring operand
	logic [33:0] hm;
	logic [67:0] hp;
	always_comb begin
		hm = (sqi_q == 2'd0) ? (dd_q[0][33] ? 34'(-dd_q[0]) : 34'(dd_q[0]))
		                     : (dd_q[2][33] ? 34'(-dd_q[2]) : 34'(dd_q[2]));
		hp = hm * hm;
	end

	// one root bit a cycle
	logic [34:0] rc;
	logic [69:0] rc2;
	always_comb begin
		rc  = root_q | (35'd1 << bit_q);
		rc2 = rc * rc;
	end

	// restoring divide step
	logic [45:0] dv_tr;
	always_comb begin
		dv_tr = {rem_q, quo_q[63]} - {1'b0, (state_q == S_MOD) ? total_q : seg_q};
	end

	// interpolation of one axis
	logic signed [32:0] li_p0, li_d;
	logic [32:0]        li_m;
	logic [63:0]        li_off;
	always_comb begin
		case (ax_q)
			2'd0:    begin li_p0 = 33'(signed'(pa_q[95:64]));
			          li_d = 33'(signed'(pb_q[95:64])) - li_p0; end
			2'd1:    begin li_p0 = 33'(signed'(pa_q[63:32]));
			          li_d = 33'(signed'(pb_q[63:32])) - li_p0; end
			default: begin li_p0 = 33'(signed'(pa_q[31:0]));
			          li_d = 33'(signed'(pb_q[31:0])) - li_p0; end
		endcase
		li_m   = li_d[32] ? 33'(-li_d) : 33'(li_d);
		li_off = li_m * t_q;
	end

	// CORDIC step with floor shifts
	logic signed [47:0] cx_sh, cy_sh;
	logic [47:0]        ax_mag, ay_mag;
	always_comb begin
		cx_sh  = ax_x_q >>> ci_q;
		cy_sh  = ax_y_q >>> ci_q;
		ax_mag = ax_x_q[47] ? 48'(-ax_x_q) : 48'(ax_x_q);
		ay_mag = ax_y_q[47] ? 48'(-ax_y_q) : 48'(ax_y_q);
	end

	assign in_ready  = (state_q == S_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pt_addr(pid_q, idx_q);
		ram_wdata = {cmd_q.point_x, cmd_q.point_y, cmd_q.point_z};
		unique case (state_q)
			S_LOAD: begin
				ram_we   = (cmd_q.kind == cpcf_pkg::KIND_START) || (cnt_q[pid_q] < CW'(POINTS_PER_PATH));
				ram_addr = pt_addr(pid_q, (cmd_q.kind == cpcf_pkg::KIND_START) ? '0 : cnt_q[pid_q][PW-1:0]);
			end
			S_RD1, S_TRD1: ram_addr = pt_addr(pid_q, nxt_q);
			S_TRD2: ram_addr = pt_addr(pid_q, cmd_q.direction ? ((idx_q == '0) ? PW'(len_q - 1'b1)
			                                       : idx_q - 1'b1) : nxt_q);
			default: ram_addr = pt_addr(pid_q, idx_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			for (int k = 0; k < NUM_PATHS; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= in_data;
						pid_q <= PIDW'(in_data.path_id);
						idx_q <= '0;
						if (32'(in_data.path_id) >= NUM_PATHS) begin
							// out of range: loads and clears drop, queries answer as empty
							if (in_data.kind == cpcf_pkg::KIND_QUERY) begin
								out_q   <= '0;
								out_v_q <= 1'b1;
							end
						end else if (in_data.kind == cpcf_pkg::KIND_CLEAR) begin
							cnt_q[PIDW'(in_data.path_id)] <= '0;
						end else if (in_data.kind == cpcf_pkg::KIND_QUERY) begin
							state_q <= S_QSTART;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					if (cmd_q.kind == cpcf_pkg::KIND_START) begin
						cnt_q[pid_q] <= CW'(1);
					end else if (cnt_q[pid_q] < CW'(POINTS_PER_PATH)) begin
						cnt_q[pid_q] <= cnt_q[pid_q] + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_QSTART: begin
					len_q   <= cnt_q[pid_q];
					pass_q  <= 1'b0;
					total_q <= '0;
					cur_q   <= '0;
					idx_q   <= '0;
					nxt_q   <= wrap_next('0, cnt_q[pid_q]);
					if (cnt_q[pid_q] == '0) begin
						out_q   <= '0;
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (cnt_q[pid_q] == CW'(1)) begin
						state_q <= S_ONEPT;
					end else begin
						state_q <= S_RD0;
					end
				end
				S_ONEPT: begin
					// issue read of point 0, then wait for data
					state_q <= S_RDW;
					pass_q  <= 1'b1;
					len_q   <= CW'(1);
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					pa_q    <= ram_rdata;
					state_q <= S_RDW;
				end
				S_RDW: begin
					if (len_q == CW'(1)) begin
						out_q.cam_x <= ram_rdata[95:64];
						out_q.cam_y <= ram_rdata[63:32];
						out_q.cam_z <= ram_rdata[31:0];
						out_q.yaw   <= '0;
						out_q.pitch <= '0;
						out_q.roll  <= 1'b0;
						pa_q        <= ram_rdata;
						state_q     <= S_OUT;
						len_q       <= CW'(2);
					end else begin
						pb_q    <= ram_rdata;
						sqi_q   <= 2'd0;
						sum_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sum_q <= sum_q + 68'(sq_p);
					if (sqi_q == 2'd2) begin
						root_q  <= '0;
						bit_q   <= 6'd34;
						state_q <= S_ROOT;
					end else begin
						sqi_q <= sqi_q + 1'b1;
					end
				end
				S_ROOT: begin
					if (rc2 <= 70'(sum_q)) begin
						root_q <= rc;
					end
					if (bit_q == '0) begin
						state_q <= S_SEGDN;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_SEGDN: begin
					seg_q <= 45'(root_q);
					if (!pass_q) begin
						total_q <= total_q + 45'(root_q);
						if (CW'(idx_q) == len_q - 1'b1) begin
							// wrap the position next
							rem_q   <= '0;
							quo_q   <= cmd_q.position[31] ? 64'(-33'(cmd_q.position))
							                              : 64'(cmd_q.position);
							step_q  <= '0;
							state_q <= S_MOD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							nxt_q   <= wrap_next(idx_q + 1'b1, len_q);
							state_q <= S_RD0;
						end
					end else begin
						if (cur_q + 45'(root_q) >= pos_q || CW'(idx_q) == len_q - 1'b1) begin
							// segment found (last segment if never reached)
							rem_q   <= '0;
							quo_q   <= (root_q != '0 && pos_q > cur_q)
							           ? {34'(pos_q - cur_q), 30'd0} : '0;
							step_q  <= '0;
							state_q <= S_DIV;
						end else begin
							cur_q   <= cur_q + 45'(root_q);
							idx_q   <= idx_q + 1'b1;
							nxt_q   <= wrap_next(idx_q + 1'b1, len_q);
							state_q <= S_RD0;
						end
					end
				end
				S_MOD: begin
					if (total_q == '0) begin
						pos_q   <= '0;
						pass_q  <= 1'b1;
						idx_q   <= '0;
						nxt_q   <= wrap_next('0, len_q);
						state_q <= S_RD0;
					end else if (step_q == 7'd64) begin
						logic [44:0] p;
						p = (cmd_q.position[31] && rem_q != '0) ? total_q - rem_q : rem_q;
						pos_q   <= cmd_q.direction ? total_q - p : p;
						pass_q  <= 1'b1;
						idx_q   <= '0;
						nxt_q   <= wrap_next('0, len_q);
						state_q <= S_RD0;
					end else begin
						if (!dv_tr[45]) begin
							rem_q <= dv_tr[44:0];
						end else begin
							rem_q <= {rem_q[43:0], quo_q[63]};
						end
						quo_q  <= {quo_q[62:0], !dv_tr[45]};
						step_q <= step_q + 1'b1;
					end
				end
				S_DIV: begin
					if (seg_q == '0 || step_q == 7'd64) begin
						t_q <= (seg_q == '0) ? '0
						       : (quo_q > 64'(1 << 30)) ? 31'(1 << 30) : quo_q[30:0];
						state_q <= S_TRD0;
					end else begin
						if (!dv_tr[45]) begin
							rem_q <= dv_tr[44:0];
						end else begin
							rem_q <= {rem_q[43:0], quo_q[63]};
						end
						quo_q  <= {quo_q[62:0], !dv_tr[45]};
						step_q <= step_q + 1'b1;
					end
				end
				S_TRD0: state_q <= S_TRD1;
				S_TRD1: begin
					pa_q    <= ram_rdata;
					state_q <= S_TRD2;
				end
				S_TRD2: begin
					pb_q    <= ram_rdata;
					state_q <= S_TRDW;
				end
				S_TRDW: begin
					// target point lands the cycle after its read
					pt_q    <= ram_rdata;
					ax_q    <= 2'd0;
					state_q <= S_LERP;
				end
				S_LERP: begin
					cam_q[ax_q] <= li_d[32] ? 34'(li_p0) - 34'(li_off[63:30])
					                        : 34'(li_p0) + 34'(li_off[63:30]);
					if (ax_q == 2'd2) begin
						state_q <= S_LERP2;
					end else begin
						ax_q <= ax_q + 1'b1;
					end
				end
				S_LERP2: begin
					dd_q[0] <= 34'(signed'(pt_q[95:64])) - cam_q[0];
					dd_q[1] <= 34'(signed'(pt_q[63:32])) - cam_q[1];
					dd_q[2] <= 34'(signed'(pt_q[31:0]))  - cam_q[2];
					out_q.cam_x <= cam_q[0][31:0];
					out_q.cam_y <= cam_q[1][31:0];
					out_q.cam_z <= cam_q[2][31:0];
					out_q.roll  <= 1'b0;
					at_sel_q <= 1'b0;
					state_q  <= S_ATINIT;
				end
				S_ATINIT: begin
					logic signed [47:0] y0, x0;
					y0 = at_sel_q ? 48'(dd_q[1]) : 48'(dd_q[0]);
					x0 = at_sel_q ? 48'(signed'({1'b0, root_q})) : 48'(dd_q[2]);
					ci_q  <= '0;
					if (y0 == '0) begin
						ang_q   <= (x0 < 0) ? cpcf_pkg::DEG180 : '0;
						state_q <= S_ATDONE;
					end else if (x0 == '0) begin
						ang_q   <= (y0 > 0) ? cpcf_pkg::DEG90 : -cpcf_pkg::DEG90;
						state_q <= S_ATDONE;
					end else begin
						ang_q   <= '0;
						ax_x_q  <= x0;
						ax_y_q  <= y0;
						state_q <= S_ATNORM;
					end
				end
				S_ATNORM: begin
					if (ax_mag < (48'd1 << 40) && ay_mag < (48'd1 << 40)) begin
						ax_x_q <= ax_x_q <<< 1;
						ax_y_q <= ax_y_q <<< 1;
					end else begin
						if (ax_x_q < 0) begin
							ang_q  <= (ax_y_q > 0) ? cpcf_pkg::DEG180 : -cpcf_pkg::DEG180;
							ax_x_q <= -ax_x_q;
							ax_y_q <= -ax_y_q;
						end
						state_q <= S_ATRUN;
					end
				end
				S_ATRUN: begin
					if (ax_y_q == '0 || 32'(ci_q) == cpcf_pkg::CORDIC_STEPS) begin
						state_q <= S_ATDONE;
					end else begin
						if (ax_y_q > 0) begin
							ax_x_q <= ax_x_q + cy_sh;
							ax_y_q <= ax_y_q - cx_sh;
							ang_q  <= ang_q + 48'(cpcf_pkg::atan_tab(ci_q));
						end else begin
							ax_x_q <= ax_x_q - cy_sh;
							ax_y_q <= ax_y_q + cx_sh;
							ang_q  <= ang_q - 48'(cpcf_pkg::atan_tab(ci_q));
						end
						ci_q <= ci_q + 1'b1;
					end
				end
				S_ATDONE: begin
					logic signed [47:0] a;
					a = (ang_q > cpcf_pkg::DEG180) ? cpcf_pkg::DEG180
					  : (ang_q < -cpcf_pkg::DEG180) ? -cpcf_pkg::DEG180 : ang_q;
					if (!at_sel_q) begin
						yaw_q   <= cpcf_pkg::DEG360 - a;
						sum_q   <= '0;
						sqi_q   <= 2'd0;
						state_q <= S_HSQ;
					end else begin
						a = (a > cpcf_pkg::DEG90) ? cpcf_pkg::DEG90
						  : (a < -cpcf_pkg::DEG90) ? -cpcf_pkg::DEG90 : a;
						out_q.yaw   <= yaw_q[25:0];
						out_q.pitch <= 24'(-a);
						state_q     <= S_OUT;
					end
				end
				S_HSQ: begin
					sum_q <= sum_q + hp;
					if (sqi_q == 2'd1) begin
						root_q  <= '0;
						bit_q   <= 6'd34;
						state_q <= S_HROOT;
					end else begin
						sqi_q <= 2'd1;
					end
				end
				S_HROOT: begin
					if (rc2 <= 70'(sum_q)) begin
						root_q <= rc;
					end
					if (bit_q == '0) begin
						at_sel_q <= 1'b1;
						state_q  <= S_ATINIT;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench of closed_path_camera_follower_unit: directed words, then random
// path builds and camera queries in four phases of sender gaps and receiver stalls,
// checked against an own predictor. Depends on cpcf_pkg and the RTL of the block.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpcf_pkg::*;

	localparam int PATHS    = 8;
	localparam int PER_PATH = 1024;
	localparam int STALL_LIMIT = 400000;
	localparam longint signed ANG90  = 64'sd5898240;
	localparam longint signed ANG180 = 64'sd11796480;
	localparam longint signed ANG360 = 64'sd23592960;
	localparam longint signed NORM   = 64'sd1 << 40;
	localparam longint signed ROT_DEG [21] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4};

	typedef struct {
		in_word_t  w;
		bit        fixed;
		out_word_t want;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	// shadow of the point store and the per-path counts
	logic signed [31:0] shadow_x [PATHS*PER_PATH];
	logic signed [31:0] shadow_y [PATHS*PER_PATH];
	logic signed [31:0] shadow_z [PATHS*PER_PATH];
	int unsigned        shadow_len [PATHS];

	out_word_t pending_views [$];
	bit        failed = 1'b0;
	int        send_pct = 0;
	int        stall_pct = 0;
	int        quiet = 0;

	closed_path_camera_follower_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [127:0] square_of(longint signed d);
		logic [63:0] m;
		m = d < 0 ? -d : d;
		return {64'd0, m} * {64'd0, m};
	endfunction

	function automatic logic [63:0] int_root(logic [127:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 34; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] span_of(int unsigned base, int unsigned i, int unsigned n);
		int unsigned j;
		j = (i + 1 >= n) ? 0 : i + 1;
		return int_root(square_of(longint'(shadow_x[base+j]) - shadow_x[base+i])
			+ square_of(longint'(shadow_y[base+j]) - shadow_y[base+i])
			+ square_of(longint'(shadow_z[base+j]) - shadow_z[base+i]));
	endfunction

	// vectoring CORDIC in Q16.16 degrees, floor shifts, early stop on y == 0
	function automatic longint signed bearing(longint signed y, longint signed x);
		longint signed ang;
		longint signed nx;
		longint signed ny;
		ang = 0;
		if (y == 0)
			return x < 0 ? ANG180 : 0;
		if (x == 0)
			return y > 0 ? ANG90 : -ANG90;
		while ((x < 0 ? -x : x) < NORM && (y < 0 ? -y : y) < NORM) begin
			x = x * 2;
			y = y * 2;
		end
		if (x < 0) begin
			ang = y > 0 ? ANG180 : -ANG180;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 21; i++) begin
			if (y == 0)
				break;
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				ang += ROT_DEG[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				ang -= ROT_DEG[i];
			end
			x = nx;
			y = ny;
		end
		if (ang > ANG180) ang = ANG180;
		if (ang < -ANG180) ang = -ANG180;
		return ang;
	endfunction

	function automatic longint signed blend(longint signed a, longint signed b, logic [63:0] t);
		longint signed d;
		logic [63:0] off;
		d = b - a;
		off = ((d < 0 ? -d : d) * t) >> 30;
		return d < 0 ? a - longint'(off) : a + longint'(off);
	endfunction

	// update the shadow for one word; returns 1 with the camera view for a query
	function automatic bit camera_view(in_word_t w, output out_word_t v);
		int unsigned base, n, slot, first, nxt, tgt;
		longint signed p, cx, cy, cz, dx, dy, dz, yaw, pitch;
		logic [63:0] loop_len, pos, cur, seg, m, t;
		v = '0;
		base = w.path_id * PER_PATH;
		if (w.kind != KIND_QUERY) begin
			if (w.kind == KIND_CLEAR) begin
				shadow_len[w.path_id] = 0;
			end else begin
				slot = (w.kind == KIND_START) ? 0 : shadow_len[w.path_id];
				if (slot < PER_PATH) begin
					shadow_x[base+slot] = w.point_x;
					shadow_y[base+slot] = w.point_y;
					shadow_z[base+slot] = w.point_z;
					shadow_len[w.path_id] = slot + 1;
				end
			end
			return 1'b0;
		end
		n = shadow_len[w.path_id];
		if (n == 0)
			return 1'b1;
		if (n == 1) begin
			v.cam_x = shadow_x[base];
			v.cam_y = shadow_y[base];
			v.cam_z = shadow_z[base];
			return 1'b1;
		end
		loop_len = 0;
		for (int unsigned i = 0; i < n; i++)
			loop_len += span_of(base, i, n);
		p = {{32{w.position[31]}}, w.position};
		if (loop_len == 0) begin
			pos = 0;
		end else if (p >= 0) begin
			pos = unsigned'(p) % loop_len;
		end else begin
			m = unsigned'(-p) % loop_len;
			pos = m != 0 ? loop_len - m : 0;
		end
		if (w.direction)
			pos = loop_len - pos;
		cur = 0;
		first = 0;
		seg = 0;
		for (int unsigned i = 0; i < n; i++) begin
			seg = span_of(base, i, n);
			if (cur + seg >= pos) begin
				first = i;
				break;
			end
			cur += seg;
		end
		// 64-bit wrap of the shifted numerator is part of the arithmetic
		t = (seg != 0 && pos > cur) ? ((pos - cur) << 30) / seg : 0;
		if (t > (64'd1 << 30))
			t = 64'd1 << 30;
		nxt = (first + 1 >= n) ? 0 : first + 1;
		cx = blend(shadow_x[base+first], shadow_x[base+nxt], t);
		cy = blend(shadow_y[base+first], shadow_y[base+nxt], t);
		cz = blend(shadow_z[base+first], shadow_z[base+nxt], t);
		tgt = !w.direction ? nxt : (first == 0 ? n - 1 : first - 1);
		dx = longint'(shadow_x[base+tgt]) - cx;
		dy = longint'(shadow_y[base+tgt]) - cy;
		dz = longint'(shadow_z[base+tgt]) - cz;
		yaw = ANG360 - bearing(dx, dz);
		pitch = bearing(dy, longint'(int_root(square_of(dx) + square_of(dz))));
		if (pitch > ANG90) pitch = ANG90;
		if (pitch < -ANG90) pitch = -ANG90;
		pitch = -pitch;
		v.cam_x = cx[31:0];
		v.cam_y = cy[31:0];
		v.cam_z = cz[31:0];
		v.yaw   = yaw[25:0];
		v.pitch = pitch[23:0];
		v.roll  = 1'b0;
		return 1'b1;
	endfunction

	function automatic in_word_t word(logic [1:0] kind, int pid, int x, int y, int z,
		bit dir, int pos);
		in_word_t w;
		w.kind = kind;
		w.path_id = pid[2:0];
		w.point_x = x;
		w.point_y = y;
		w.point_z = z;
		w.direction = dir;
		w.position = pos;
		return w;
	endfunction

	function automatic out_word_t view(int x, int y, int z, int yaw, int pitch);
		out_word_t v;
		v.cam_x = x;
		v.cam_y = y;
		v.cam_z = z;
		v.yaw = yaw[25:0];
		v.pitch = pitch[23:0];
		v.roll = 1'b0;
		return v;
	endfunction

	// coordinate: half the time any 32-bit value, else near the origin
	function automatic int coord();
		if ($urandom_range(1))
			return int'($urandom());
		return int'($urandom_range(1 << 20)) - (1 << 19);
	endfunction

	function automatic int spot();
		if ($urandom_range(1))
			return int'($urandom());
		return int'($urandom_range(1 << 22));
	endfunction

	// offer one word, hold it until taken, then predict and idle for a random gap, which may be none
	task automatic offer(in_word_t w, bit fixed = 1'b0, out_word_t want = '0);
		out_word_t v;
		int gap;
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		if (camera_view(w, v))
			pending_views.push_back(fixed ? want : v);
		gap = 0;
		while (send_pct != 0 && $urandom_range(99) < send_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver, result check and watchdog, all on the rising edge
	always @(posedge clk) begin
		out_word_t want;
		out_ready <= ($urandom_range(99) >= stall_pct);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("closed_path_camera_follower_unit: mismatch");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_views.size() == 0) begin
				$display("%0t: unexpected result word %h", $realtime, out_data);
				failed = 1'b1;
			end else begin
				want = pending_views.pop_front();
				if (out_data.cam_x !== want.cam_x) begin
					$display("%0t: cam_x expected %h got %h", $realtime, want.cam_x,
						out_data.cam_x);
					failed = 1'b1;
				end
				if (out_data.cam_y !== want.cam_y) begin
					$display("%0t: cam_y expected %h got %h", $realtime, want.cam_y,
						out_data.cam_y);
					failed = 1'b1;
				end
				if (out_data.cam_z !== want.cam_z) begin
					$display("%0t: cam_z expected %h got %h", $realtime, want.cam_z,
						out_data.cam_z);
					failed = 1'b1;
				end
				if (out_data.yaw !== want.yaw) begin
					$display("%0t: yaw expected %h got %h", $realtime, want.yaw,
						out_data.yaw);
					failed = 1'b1;
				end
				if (out_data.pitch !== want.pitch) begin
					$display("%0t: pitch expected %h got %h", $realtime, want.pitch,
						out_data.pitch);
					failed = 1'b1;
				end
				if (out_data.roll !== want.roll) begin
					$display("%0t: roll expected %b got %b", $realtime, want.roll,
						out_data.roll);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		in_word_t w;
		int sent, pid, k;
		for (int i = 0; i < PATHS; i++)
			shadow_len[i] = 0;

		// directed rows: empty path, append to empty, extremes, exact axes, zero-length loop
		rows.push_back('{word(KIND_QUERY, 0, 0, 0, 0, 0, 0), 1, view(0, 0, 0, 0, 0)});
		rows.push_back('{word(KIND_CLEAR, 7, 0, 0, 0, 1, 0), 0, '0});
		rows.push_back('{word(KIND_APPEND, 2, 32'h7fffffff, 32'h80000000, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_QUERY, 2, 0, 0, 0, 1, -1), 1,
			view(32'h7fffffff, 32'h80000000, 0, 0, 0)});
		rows.push_back('{word(KIND_START, 1, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_APPEND, 1, 65536, 0, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_QUERY, 1, 0, 0, 0, 0, 0), 1,
			view(0, 0, 0, 17694720, 0)});
		rows.push_back('{word(KIND_QUERY, 1, 0, 0, 0, 1, 32'h7fffffff), 0, '0});
		rows.push_back('{word(KIND_QUERY, 1, 0, 0, 0, 0, 32'h80000000), 0, '0});
		rows.push_back('{word(KIND_START, 3, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_APPEND, 3, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_QUERY, 3, 0, 0, 0, 1, 12345), 0, '0});
		rows.push_back('{word(KIND_START, 4, -65536, 32'h7fffffff, 32'h80000000, 0, 0), 0, '0});
		rows.push_back('{word(KIND_APPEND, 4, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0),
			0, '0});
		rows.push_back('{word(KIND_APPEND, 4, 0, 0, -5, 0, 0), 0, '0});
		rows.push_back('{word(KIND_QUERY, 4, 0, 0, 0, 0, 32'h5a5a5a5a), 0, '0});
		rows.push_back('{word(KIND_QUERY, 4, -1, -1, -1, 1, -1), 0, '0});
		rows.push_back('{word(KIND_START, 5, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_APPEND, 5, 0, 65536, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_QUERY, 5, 0, 0, 0, 0, 0), 1,
			view(0, 0, 0, 23592960, -5898240)});
		rows.push_back('{word(KIND_START, 6, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_APPEND, 6, 0, 0, -65536, 0, 0), 0, '0});
		rows.push_back('{word(KIND_QUERY, 6, 0, 0, 0, 0, 0), 1,
			view(0, 0, 0, 11796480, 0)});
		rows.push_back('{word(KIND_CLEAR, 1, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{word(KIND_QUERY, 1, 0, 0, 0, 0, 0), 1, view(0, 0, 0, 0, 0)});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r])
			offer(rows[r].w, rows[r].fixed, rows[r].want);

		// hold the sender until every view is back
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_views.size() != 0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 84; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 84; end
				default: begin send_pct = 9; stall_pct = 9; end
			endcase
			sent = 0;
			while (sent < 20) begin
				pid = $urandom_range(7);
				if ($urandom_range(99) < 70) begin
					// well-formed: a fresh short loop and a few views of it
					offer(word(KIND_START, pid, coord(), coord(), coord(), 0, 0));
					k = $urandom_range(5);
					repeat (k)
						offer(word(KIND_APPEND, pid, coord(), coord(), coord(), 0, 0));
					repeat ($urandom_range(1, 3))
						offer(word(KIND_QUERY, pid, coord(), coord(), coord(),
							1'($urandom_range(1)), spot()));
					sent += k + 3;
				end else begin
					w = word(2'($urandom_range(3)), pid, coord(), coord(), coord(),
						1'($urandom_range(1)), spot());
					// keep noise from growing loops far
					if (w.kind == KIND_APPEND && shadow_len[pid] >= 24)
						w.kind = KIND_CLEAR;
					offer(w);
					sent++;
				end
			end
			in_valid <= 1'b0;
			do @(posedge clk); while (pending_views.size() != 0);
		end

		repeat (200) @(posedge clk);
		if (!failed)
			$display("closed_path_camera_follower_unit: match");
		else
			$display("closed_path_camera_follower_unit: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
